[src/ip_prefix_allow_table_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the prefix allow table
// Concurrent checks sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef IP_PREFIX_ALLOW_TABLE_CORE_ASSERT_SVH
`define IP_PREFIX_ALLOW_TABLE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ipat_pkg.sv]
// ----------------------------------------------------------------------------
// ipat_pkg
// Types, codes and the prefix mask function shared by the allow table files.
// ----------------------------------------------------------------------------
package ipat_pkg;

  localparam int unsigned AddrW = 128;
  localparam int unsigned V4W   = 32;
  localparam int unsigned PfxW  = 8;

  localparam logic [PfxW-1:0] V6MaxPfx = 8'd128;
  localparam logic [PfxW-1:0] V4MaxPfx = 8'd32;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_LOOKUP = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_INVALID   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } fsm_e;

  typedef struct packed {
    logic             valid;
    logic             is_ipv6;
    logic [AddrW-1:0] addr;
    logic [PfxW-1:0]  prefix;
  } entry_t;

  typedef struct packed {
    logic             lookup;
    logic             is_ipv6;
    logic [AddrW-1:0] addr;
    logic [PfxW-1:0]  prefix;
  } key_t;

  // IPv6 masks cover all 128 bits from the top; IPv4 masks cover the low 32 bits.
  function automatic logic [AddrW-1:0] prefix_mask(input logic v6, input logic [PfxW-1:0] p);
    logic [AddrW-1:0] m;
    m = '0;
    for (int j = 0; j < AddrW; j++) begin
      if (v6 && (PfxW'(j) < p)) begin
        m[AddrW-1-j] = 1'b1;
      end
    end
    for (int j = 0; j < V4W; j++) begin
      if (!v6 && (PfxW'(j) < p)) begin
        m[V4W-1-j] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

[src/ipat_cmp.sv]
// ----------------------------------------------------------------------------
// ipat_cmp
// Compares one stored entry against the search key of the current item.
// ----------------------------------------------------------------------------
module ipat_cmp import ipat_pkg::*; (
  input  entry_t slot_i,
  input  key_t   key_i,
  output logic   match_o
);

  logic [AddrW-1:0] slot_mask;
  logic             fam_ok;
  logic             exact;
  logic             covers;

  always_comb begin
    slot_mask = prefix_mask(slot_i.is_ipv6, slot_i.prefix);
    fam_ok    = slot_i.valid && (slot_i.is_ipv6 == key_i.is_ipv6);
    exact     = (slot_i.addr == key_i.addr) && (slot_i.prefix == key_i.prefix);
    covers    = ((key_i.addr & slot_mask) == slot_i.addr);
    match_o   = fam_ok && (key_i.lookup ? covers : exact);
  end

endmodule

[src/ip_prefix_allow_table_core.sv]
// ----------------------------------------------------------------------------
// ip_prefix_allow_table_core
// IPv4/IPv6 allow-list table with add, remove and prefix lookup.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_ready_o   mode, family, address, mask, prefix
//  out      output     out_valid_o / out_ready_i status, hit, entries_used
//
// A valid item scans every table entry: the table memory is read one entry per cycle.
// An item rejected as invalid skips the scan and goes straight to the finish state.
// After reset a clearing pass writes every table entry before the first item is taken.
// A new item is taken while a result waits; its write-back waits for the result slot.
// ----------------------------------------------------------------------------
`include "ip_prefix_allow_table_core_assert.svh"

module ip_prefix_allow_table_core import ipat_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic        is_ipv6_i,
  input  logic [63:0] addr_high_i,
  input  logic [63:0] addr_low_i,
  input  logic [31:0] ipv4_mask_i,
  input  logic [7:0]  prefix_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        hit_o,
  output logic [6:0]  entries_used_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] LastIdx = CntW'(TABLE_ENTRIES - 1);
  localparam logic [CntW-1:0] ScanEnd = CntW'(TABLE_ENTRIES);

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_q;

  fsm_e            state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] cmp_idx_q;
  logic            rd_en;

  key_t            key_q;
  mode_e           mode_q;
  logic            err_q;

  logic            found_q;
  logic [IdxW-1:0] found_idx_q;
  logic            free_q;
  logic [IdxW-1:0] free_idx_q;
  logic            slot_match;

  logic [CntW-1:0] used_q, used_d;

  logic            out_valid_q;
  status_e         status_q;
  logic            hit_q;
  logic [6:0]      eused_q;

  logic            mem_we;
  logic [IdxW-1:0] mem_widx;
  entry_t          mem_wdata;

  logic            in_ready;
  logic            in_take;
  logic            load_out;
  logic            out_free;
  status_e         fin_status;
  logic            fin_hit;

  logic [AddrW-1:0] key_raw;
  logic [AddrW-1:0] in_addr;
  logic [PfxW-1:0]  in_pfx;
  logic             in_err;
  logic             in_lookup;
  logic [V4W-1:0]   inv4;
  logic [V4W:0]     t4;
  logic             mask_ok;
  logic [5:0]       pos4;
  logic [PfxW-1:0]  p4;

  // Item decode: validity check, IPv4 mask to prefix length on add, host bits cleared except on lookup.
  always_comb begin
    key_raw = is_ipv6_i ? {addr_high_i, addr_low_i}
                        : {{(AddrW-V4W){1'b0}}, addr_low_i[V4W-1:0]};
    inv4    = ~ipv4_mask_i;
    t4      = {1'b0, inv4} + {{V4W{1'b0}}, 1'b1};
    mask_ok = ((inv4 & t4[V4W-1:0]) == '0);
    pos4    = '0;
    for (int k = 0; k <= V4W; k++) begin
      if (t4[k]) begin
        pos4 = pos4 | 6'(k);
      end
    end
    p4        = V4MaxPfx - {2'b00, pos4};
    in_err    = 1'b1;
    in_lookup = 1'b0;
    in_pfx    = prefix_length_i;
    in_addr   = key_raw & prefix_mask(is_ipv6_i, prefix_length_i);
    unique case (mode_i)
      MODE_ADD: begin
        if (is_ipv6_i) begin
          in_err = (prefix_length_i > V6MaxPfx);
        end else begin
          in_err  = !mask_ok;
          in_pfx  = p4;
          in_addr = key_raw & {{(AddrW-V4W){1'b0}}, ipv4_mask_i};
        end
      end
      MODE_REMOVE: begin
        in_err = (prefix_length_i > (is_ipv6_i ? V6MaxPfx : V4MaxPfx));
      end
      MODE_LOOKUP: begin
        in_err    = 1'b0;
        in_lookup = 1'b1;
        in_addr   = key_raw;
      end
      default: begin
        in_err = 1'b1;
      end
    endcase
  end

  ipat_cmp u_cmp (
    .slot_i  (rd_q),
    .key_i   (key_q),
    .match_o (slot_match)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmp_vld_d  = 1'b0;
    rd_en      = 1'b0;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    out_free   = !out_valid_q || out_ready_i;
    used_d     = used_q;
    fin_status = ST_OK;
    fin_hit    = 1'b0;
    mem_we     = 1'b0;
    mem_widx   = cnt_q[IdxW-1:0];
    mem_wdata  = '0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          cnt_d   = '0;
          state_d = in_err ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q != ScanEnd) begin
          rd_en     = 1'b1;
          cmp_vld_d = 1'b1;
          cnt_d     = cnt_q + 1'b1;
        end else if (cmp_vld_q) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (err_q) begin
          fin_status = ST_INVALID;
        end else begin
          unique case (mode_q)
            MODE_ADD: begin
              if (found_q) begin
                fin_status = ST_DUP;
              end else if (free_q) begin
                mem_we            = out_free;
                mem_widx          = free_idx_q;
                mem_wdata.valid   = 1'b1;
                mem_wdata.is_ipv6 = key_q.is_ipv6;
                mem_wdata.addr    = key_q.addr;
                mem_wdata.prefix  = key_q.prefix;
                used_d            = used_q + 1'b1;
              end else begin
                fin_status = ST_FULL;
              end
            end
            MODE_REMOVE: begin
              if (found_q) begin
                mem_we   = out_free;
                mem_widx = found_idx_q;
                if (used_q != '0) begin
                  used_d = used_q - 1'b1;
                end
              end else begin
                fin_status = ST_NOT_FOUND;
              end
            end
            MODE_LOOKUP: begin
              fin_hit = found_q;
            end
            default: begin
              fin_status = ST_INVALID;
            end
          endcase
        end
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end else begin
          used_d = used_q;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  assign in_take = in_valid_i && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      cmp_vld_q   <= 1'b0;
      used_q      <= '0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      used_q    <= used_d;
      if (in_take) begin
        found_q <= 1'b0;
        free_q  <= 1'b0;
      end else if (cmp_vld_q) begin
        if (slot_match && !found_q) begin
          found_q <= 1'b1;
        end
        if (!rd_q.valid && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      key_q.lookup  <= in_lookup;
      key_q.is_ipv6 <= is_ipv6_i;
      key_q.addr    <= in_addr;
      key_q.prefix  <= in_pfx;
      mode_q        <= mode_e'(mode_i);
      err_q         <= in_err;
    end
    if (cmp_vld_q) begin
      if (slot_match && !found_q) begin
        found_idx_q <= cmp_idx_q;
      end
      if (!rd_q.valid && !free_q) begin
        free_idx_q <= cmp_idx_q;
      end
    end
    if (load_out) begin
      status_q <= fin_status;
      hit_q    <= fin_hit;
      eused_q  <= 7'(used_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_widx] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q      <= mem[cnt_q[IdxW-1:0]];
      cmp_idx_q <= cnt_q[IdxW-1:0];
    end
  end

  assign in_ready_o     = in_ready;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign hit_o          = hit_q;
  assign entries_used_o = eused_q;

  `IPAT_ASSERT_NOW(a_used_bound, 1'b1, used_q <= ScanEnd, "Entry count exceeds the table size.")
  `IPAT_ASSERT_NOW(a_write_phase, mem_we, (state_q == S_CLEAR) || (state_q == S_FINISH), "Table written outside the clear or finish phase.")
  `IPAT_ASSERT_NOW(a_result_src, $rose(out_valid_q), $past(state_q) == S_FINISH, "Result raised without a finished item.")
  `IPAT_ASSERT_NEXT(a_item_start, in_valid_i && in_ready_o, (state_q == S_SCAN) || (state_q == S_FINISH), "Accepted item did not start.")

endmodule
